### rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg: shared types and codes for the double-ended queue core
// Operation codes, result status codes, and the decoded command word that
// travels from the front decoder through the command queue to the back end.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int unsigned OPCODE_W   = 3;
    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned STATUS_W   = 2;

    // depth of the command queue between front and back
    localparam int unsigned CMD_Q_DEPTH = 2;

    localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_DUMP_FWD   = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_DUMP_BWD   = 3'd5;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    typedef enum logic [2:0] {
        K_PUSH_FRONT,
        K_PUSH_BACK,
        K_POP_FRONT,
        K_POP_BACK,
        K_DUMP_FWD,
        K_DUMP_BWD
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                  kind;
        logic signed [VALUE_W-1:0]  value;
    } cmd_t;

endpackage

### rtl/deq_front.sv
// ----------------------------------------------------------------------------
// deq_front: command decoder
// Takes command words from the start/busy port, decodes the opcode and posts
// valid commands to the command queue. Unknown opcodes are dropped here.
// ----------------------------------------------------------------------------
module deq_front (
    input  logic                                start,
    input  logic [deq_pkg::OPCODE_W-1:0]        opcode,
    input  logic signed [deq_pkg::VALUE_W-1:0]  push_value,
    input  logic                                q_full,
    output logic                                busy,
    output logic                                q_wr,
    output deq_pkg::cmd_t                       q_cmd
);
    import deq_pkg::*;

    logic       accept;
    logic       known;
    cmd_kind_t  kind;

    assign busy   = q_full;
    assign accept = start && !q_full;

    always_comb
    begin
        known = 1'b1;
        kind  = K_PUSH_FRONT;
        case (opcode)
            OP_PUSH_FRONT: kind = K_PUSH_FRONT;
            OP_PUSH_BACK:  kind = K_PUSH_BACK;
            OP_POP_FRONT:  kind = K_POP_FRONT;
            OP_POP_BACK:   kind = K_POP_BACK;
            OP_DUMP_FWD:   kind = K_DUMP_FWD;
            OP_DUMP_BWD:   kind = K_DUMP_BWD;
            default:       known = 1'b0;
        endcase
    end

    assign q_wr        = accept && known;
    assign q_cmd.kind  = kind;
    assign q_cmd.value = push_value;

endmodule

### rtl/deq_cmd_fifo.sv
// ----------------------------------------------------------------------------
// deq_cmd_fifo: short command queue
// Small first-in first-out queue of decoded commands that decouples the
// decoder from the back end. Head word is presented combinationally.
// ----------------------------------------------------------------------------
module deq_cmd_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr,
    input  deq_pkg::cmd_t   wr_cmd,
    input  logic            rd,
    output deq_pkg::cmd_t   head,
    output logic            empty,
    output logic            full
);
    import deq_pkg::*;

    localparam int unsigned PTR_W = (CMD_Q_DEPTH > 1) ? $clog2(CMD_Q_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(CMD_Q_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CMD_Q_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CMD_Q_DEPTH);

    cmd_t               slot_reg [CMD_Q_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_wr, do_rd;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == CNT_FULL);
    assign head  = slot_reg[rd_ptr_reg];
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

### rtl/deq_back.sv
// ----------------------------------------------------------------------------
// deq_back: queue execution unit
// Owns the ring store, front index and entry count. Executes one command
// from the queue per cycle while not dumping; dumps stream one stored word per cycle.
// ----------------------------------------------------------------------------
module deq_back #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  deq_pkg::cmd_t                       head,
    input  logic                                q_empty,
    output logic                                q_rd,
    output logic                                done,
    output logic [deq_pkg::STATUS_W-1:0]        status,
    output logic signed [deq_pkg::VALUE_W-1:0]  item_value,
    output logic                                last
);
    import deq_pkg::*;

    localparam int unsigned IW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
    localparam logic [CW:0]   DEPTH_X  = (CW + 1)'(DEPTH);
    localparam logic [IW-1:0] IDX_LAST = IW'(DEPTH - 1);

    typedef enum logic {
        ST_CMD,
        ST_DUMP
    } state_t;

    // ring store
    logic signed [VALUE_W-1:0]  ring_mem [DEPTH];
    logic signed [VALUE_W-1:0]  rd_data_reg;
    logic                       mem_we, mem_re;
    logic [IW-1:0]              mem_waddr, mem_raddr;

    state_t                     state_reg, state_next;
    logic [IW-1:0]              front_reg, front_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [CW-1:0]              off_reg, off_next;
    logic                       bwd_reg, bwd_next;
    logic                       done_reg, done_next;
    logic                       last_reg, last_next;
    logic                       sel_mem_reg, sel_mem_next;
    logic [STATUS_W-1:0]        status_reg, status_next;
    logic signed [VALUE_W-1:0]  value_reg, value_next;

    logic                       is_full, is_empty, dump_end;
    logic [CW-1:0]              count_m1;

    // (base + off) mod DEPTH, with both terms below DEPTH
    function automatic logic [IW-1:0] add_mod(input logic [IW-1:0] base,
                                              input logic [CW-1:0] off);
        logic [CW:0] s;
        s = {{(CW + 1 - IW){1'b0}}, base} + {1'b0, off};
        if (s >= DEPTH_X)
        begin
            s = s - DEPTH_X;
        end
        return s[IW-1:0];
    endfunction

    assign is_full  = (count_reg == CNT_FULL);
    assign is_empty = (count_reg == '0);
    assign count_m1 = count_reg - 1'b1;
    assign dump_end = (off_reg == count_m1);

    always_comb
    begin
        state_next   = state_reg;
        front_next   = front_reg;
        count_next   = count_reg;
        off_next     = off_reg;
        bwd_next     = bwd_reg;
        done_next    = 1'b0;
        last_next    = 1'b0;
        sel_mem_next = 1'b0;
        status_next  = status_reg;
        value_next   = value_reg;
        q_rd         = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_waddr    = front_reg;
        mem_raddr    = front_reg;

        case (state_reg)
            ST_CMD:
            begin
                if (!q_empty)
                begin
                    q_rd = 1'b1;
                    case (head.kind)
                        K_PUSH_FRONT, K_PUSH_BACK:
                        begin
                            done_next  = 1'b1;
                            last_next  = 1'b1;
                            value_next = head.value;
                            if (is_full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                status_next = STAT_OK;
                                mem_we      = 1'b1;
                                count_next  = count_reg + 1'b1;
                                if (head.kind == K_PUSH_FRONT)
                                begin
                                    front_next = (front_reg == '0) ? IDX_LAST
                                                                   : front_reg - 1'b1;
                                    mem_waddr  = front_next;
                                end
                                else
                                begin
                                    mem_waddr = add_mod(front_reg, count_reg);
                                end
                            end
                        end
                        K_POP_FRONT, K_POP_BACK:
                        begin
                            done_next = 1'b1;
                            last_next = 1'b1;
                            if (is_empty)
                            begin
                                status_next = STAT_EMPTY;
                                value_next  = '0;
                            end
                            else
                            begin
                                status_next  = STAT_OK;
                                sel_mem_next = 1'b1;
                                mem_re       = 1'b1;
                                count_next   = count_m1;
                                if (head.kind == K_POP_FRONT)
                                begin
                                    mem_raddr  = front_reg;
                                    front_next = add_mod(front_reg, CW'(1));
                                end
                                else
                                begin
                                    mem_raddr = add_mod(front_reg, count_m1);
                                end
                            end
                        end
                        K_DUMP_FWD, K_DUMP_BWD:
                        begin
                            if (is_empty)
                            begin
                                done_next   = 1'b1;
                                last_next   = 1'b1;
                                status_next = STAT_EMPTY;
                                value_next  = '0;
                            end
                            else
                            begin
                                off_next   = '0;
                                bwd_next   = (head.kind == K_DUMP_BWD);
                                state_next = ST_DUMP;
                            end
                        end
                        default:
                        begin
                            q_rd = 1'b1;
                        end
                    endcase
                end
            end
            ST_DUMP:
            begin
                mem_re       = 1'b1;
                mem_raddr    = bwd_reg ? add_mod(front_reg, count_m1 - off_reg)
                                       : add_mod(front_reg, off_reg);
                done_next    = 1'b1;
                status_next  = STAT_OK;
                sel_mem_next = 1'b1;
                last_next    = dump_end;
                off_next     = off_reg + 1'b1;
                if (dump_end)
                begin
                    state_next = ST_CMD;
                end
            end
            default:
            begin
                state_next = ST_CMD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CMD;
            front_reg   <= '0;
            count_reg   <= '0;
            off_reg     <= '0;
            bwd_reg     <= 1'b0;
            done_reg    <= 1'b0;
            last_reg    <= 1'b0;
            sel_mem_reg <= 1'b0;
            status_reg  <= STAT_OK;
            value_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            front_reg   <= front_next;
            count_reg   <= count_next;
            off_reg     <= off_next;
            bwd_reg     <= bwd_next;
            done_reg    <= done_next;
            last_reg    <= last_next;
            sel_mem_reg <= sel_mem_next;
            status_reg  <= status_next;
            value_reg   <= value_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[mem_waddr] <= head.value;
        end
        if (mem_re)
        begin
            rd_data_reg <= ring_mem[mem_raddr];
        end
    end

    assign done       = done_reg;
    assign last       = last_reg;
    assign status     = status_reg;
    assign item_value = sel_mem_reg ? rd_data_reg : value_reg;

endmodule

### rtl/double_ended_queue_core.sv
// ----------------------------------------------------------------------------
// double_ended_queue_core: bounded double-ended queue of signed 32-bit words
// Ring-store deque with push/pop at either end and ordered dumps.
// ----------------------------------------------------------------------------
// Usage
//   Command channel: drive opcode and push_value with start high; the word is
//   taken at a rising edge where start is high and busy is low. Opcodes 6 and
//   7 are taken and ignored (no result).
//   Result channel: done marks one result word for exactly one cycle on
//   status, item_value and last. The receiver cannot stall; every result is
//   taken in the cycle it is shown. last flags the final word of a command.
// Execution / throughput
//   A decoded command waits in a two-entry command queue, then the back end
//   executes it and registers its result. Pushes and pops complete one per
//   cycle while the back end is not streaming a dump.
//   A dump of N stored words occupies the back end for one start step in
//   ST_CMD, then one store read per cycle in ST_DUMP; an empty dump or pop
//   gives one word with status empty.
//   busy is high while the command queue is full, i.e. during long dumps.
// Reset
//   rst_n clears the deque to empty and the command queue; the store
//   contents themselves are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module double_ended_queue_core #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [deq_pkg::OPCODE_W-1:0]        opcode,
    input  logic signed [deq_pkg::VALUE_W-1:0]  push_value,
    output logic                                done,
    output logic [deq_pkg::STATUS_W-1:0]        status,
    output logic signed [deq_pkg::VALUE_W-1:0]  item_value,
    output logic                                last
);
    import deq_pkg::*;

    cmd_t   q_cmd;
    cmd_t   q_head;
    logic   q_wr, q_rd, q_empty, q_full;

    // front: decode and post to the queue
    deq_front u_front (
        .start      (start),
        .opcode     (opcode),
        .push_value (push_value),
        .q_full     (q_full),
        .busy       (busy),
        .q_wr       (q_wr),
        .q_cmd      (q_cmd)
    );

    // short queue between decoder and execution unit
    deq_cmd_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (q_wr),
        .wr_cmd (q_cmd),
        .rd     (q_rd),
        .head   (q_head),
        .empty  (q_empty),
        .full   (q_full)
    );

    // back: ring store, indices and result generation
    deq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .q_empty    (q_empty),
        .q_rd       (q_rd),
        .done       (done),
        .status     (status),
        .item_value (item_value),
        .last       (last)
    );

    // an empty result carries a zero word and closes its command
    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STAT_EMPTY) |-> (item_value == '0 && last))
        else $error("empty result with non-zero word or no last flag");

    // error statuses are single-word results
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != STAT_OK) |-> last)
        else $error("error status without last flag");

    // the queue only fills through an accepted command word
    a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && !busy))
        else $error("busy rose without an accepted command");

endmodule
